FILE: hw/rtl/hgni_pkg.sv
package hgni_pkg;

    localparam int CW = 11;
    localparam int CELL_W = 22;

    typedef enum logic {
        REG_COLS = 1'b0,
        REG_ROWS = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        SIDE_W  = 3'd0,
        SIDE_DW = 3'd1,
        SIDE_DE = 3'd2,
        SIDE_E  = 3'd3,
        SIDE_UE = 3'd4,
        SIDE_UW = 3'd5
    } side_t;

    typedef struct packed {
        logic          bad;
        logic [CW-1:0] nbr_c;
        logic [CW-1:0] nbr_r;
        logic [CW-1:0] edge_c;
        logic [CW-1:0] edge_r;
        logic [CW-1:0] vert_c;
        logic [CW-1:0] vert_r;
        logic [CW-1:0] nc;
        logic [1:0]    edge_off;
        logic          vert_odd;
    } coord_t;

endpackage

FILE: hw/rtl/hgni_coord.sv
module hgni_coord
    import hgni_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic [9:0]    column,
    input  logic [9:0]    row,
    input  logic [2:0]    side,
    input  logic [CW-1:0] nc,
    input  logic [CW-1:0] nr,
    output logic          valid_reg,
    output coord_t        coord_reg
);

    logic [CW-1:0] col_w, row_w;
    logic [CW-1:0] mx, px, my, py;
    logic          even;
    logic [CW-1:0] nb2_c, nb3_c, nb4_c;
    coord_t        coord_next;

    always_comb
    begin
        col_w = {1'b0, column};
        row_w = {1'b0, row};
        even  = ~row[0];
        mx = (col_w == '0) ? nc - 11'd1 : col_w - 11'd1;
        px = (col_w == nc - 11'd1) ? '0 : col_w + 11'd1;
        my = (row_w == '0) ? nr - 11'd1 : row_w - 11'd1;
        py = (row_w == nr - 11'd1) ? '0 : row_w + 11'd1;
        nb2_c = even ? col_w : px;
        nb3_c = px;
        nb4_c = even ? col_w : px;

        coord_next     = '0;
        coord_next.nc  = nc;
        coord_next.bad = (side > SIDE_UW) || (col_w >= nc) || (row_w >= nr);

        case (side)
            SIDE_W:
            begin
                coord_next.nbr_c = mx;
                coord_next.nbr_r = row_w;
            end
            SIDE_DW:
            begin
                coord_next.nbr_c = even ? mx : col_w;
                coord_next.nbr_r = my;
            end
            SIDE_DE:
            begin
                coord_next.nbr_c = nb2_c;
                coord_next.nbr_r = my;
            end
            SIDE_E:
            begin
                coord_next.nbr_c = nb3_c;
                coord_next.nbr_r = row_w;
            end
            SIDE_UE:
            begin
                coord_next.nbr_c = nb4_c;
                coord_next.nbr_r = py;
            end
            default:
            begin
                coord_next.nbr_c = even ? mx : col_w;
                coord_next.nbr_r = py;
            end
        endcase

        if (side < SIDE_E)
        begin
            coord_next.edge_c   = col_w;
            coord_next.edge_r   = row_w;
            coord_next.edge_off = side[1:0];
        end
        else
        begin
            coord_next.edge_c   = coord_next.nbr_c;
            coord_next.edge_r   = coord_next.nbr_r;
            coord_next.edge_off = 2'(side - SIDE_E);
        end

        coord_next.vert_odd = side[0];
        case (side) inside
            SIDE_W, SIDE_DW:
            begin
                coord_next.vert_c = col_w;
                coord_next.vert_r = row_w;
            end
            SIDE_DE:
            begin
                coord_next.vert_c = nb2_c;
                coord_next.vert_r = my;
            end
            SIDE_E, SIDE_UE:
            begin
                coord_next.vert_c = nb3_c;
                coord_next.vert_r = row_w;
            end
            default:
            begin
                coord_next.vert_c = nb4_c;
                coord_next.vert_r = py;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        coord_reg <= coord_next;
    end

endmodule

FILE: hw/rtl/hgni_index.sv
module hgni_index
    import hgni_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  coord_t      coord,
    output logic        done,
    output logic [19:0] neighbor_cell,
    output logic [21:0] edge_index,
    output logic [20:0] vertex_index,
    output logic        invalid
);

    // stage 2: row * columns
    logic              v2_reg;
    logic [CELL_W-1:0] pn_reg, pe_reg, pv_reg;
    logic [CW-1:0]     cn2_reg, ce2_reg, cv2_reg;
    logic [1:0]        off2_reg;
    logic              odd2_reg, bad2_reg;

    // stage 3: + column
    logic              v3_reg;
    logic [CELL_W-1:0] celln_reg, celle_reg, cellv_reg;
    logic [1:0]        off3_reg;
    logic              odd3_reg, bad3_reg;

    // stage 4: scale to edge / vertex
    logic              done_reg;
    logic [19:0]       nbr_reg;
    logic [21:0]       edge_reg;
    logic [20:0]       vert_reg;
    logic              invalid_reg;

    logic [CELL_W+1:0] edge_next;

    always_comb
    begin
        edge_next = {1'b0, celle_reg, 1'b0} + {2'b0, celle_reg} + {22'b0, off3_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v2_reg   <= in_valid;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        pn_reg   <= coord.nbr_r * coord.nc;
        pe_reg   <= coord.edge_r * coord.nc;
        pv_reg   <= coord.vert_r * coord.nc;
        cn2_reg  <= coord.nbr_c;
        ce2_reg  <= coord.edge_c;
        cv2_reg  <= coord.vert_c;
        off2_reg <= coord.edge_off;
        odd2_reg <= coord.vert_odd;
        bad2_reg <= coord.bad;

        celln_reg <= pn_reg + {11'b0, cn2_reg};
        celle_reg <= pe_reg + {11'b0, ce2_reg};
        cellv_reg <= pv_reg + {11'b0, cv2_reg};
        off3_reg  <= off2_reg;
        odd3_reg  <= odd2_reg;
        bad3_reg  <= bad2_reg;

        invalid_reg <= bad3_reg;
        nbr_reg     <= bad3_reg ? '0 : celln_reg[19:0];
        edge_reg    <= bad3_reg ? '0 : edge_next[21:0];
        vert_reg    <= bad3_reg ? '0 : {cellv_reg[19:0], odd3_reg};
    end

    assign done          = done_reg;
    assign neighbor_cell = nbr_reg;
    assign edge_index    = edge_reg;
    assign vertex_index  = vert_reg;
    assign invalid       = invalid_reg;

endmodule

FILE: hw/rtl/hex_grid_neighbor_index_top.sv
// Channel   Signals                                          Handshake
// -------   ----------------------------------------------   --------------------------
// request   column, row, side                                start && !busy
// result    neighbor_cell, edge_index, vertex_index, invalid done, one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata     APB, pready tied high
//
// One request per cycle; busy never rises.
// Pipeline stages: wrap/select, row multiply, column add, edge/vertex scale.
// Reset clears the pipeline valid bits and sets both grid sizes to 1024.
// The result strobe cannot be held off, so the pipeline never stalls.
module hex_grid_neighbor_index_top
    import hgni_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [9:0]  column,
    input  logic [9:0]  row,
    input  logic [2:0]  side,
    output logic        done,
    output logic [19:0] neighbor_cell,
    output logic [21:0] edge_index,
    output logic [20:0] vertex_index,
    output logic        invalid,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CAP_LIMIT = (1 << CW) - 1;
    localparam int COL_CAP = (MAX_COLUMNS > CAP_LIMIT) ? CAP_LIMIT : MAX_COLUMNS;
    localparam int ROW_CAP = (MAX_ROWS > CAP_LIMIT) ? CAP_LIMIT : MAX_ROWS;
    localparam logic [CW-1:0] COL_CAP_V = CW'(COL_CAP);
    localparam logic [CW-1:0] ROW_CAP_V = CW'(ROW_CAP);
    localparam logic [CW-1:0] SIZE_RST  = 11'd1024;
    localparam logic [CW-1:0] COL_EFF_RST = (SIZE_RST > COL_CAP_V) ? COL_CAP_V : SIZE_RST;
    localparam logic [CW-1:0] ROW_EFF_RST = (SIZE_RST > ROW_CAP_V) ? ROW_CAP_V : SIZE_RST;

    logic [CW-1:0] cols_reg, cols_next, rows_reg, rows_next;
    logic [CW-1:0] nc_reg, nc_next, nr_reg, nr_next;
    logic [CW-1:0] wr_val;
    logic          wr_en;
    logic          accept;
    logic          s1_valid;
    coord_t        s1_coord;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;
    assign wr_en  = psel && penable && pwrite && pready;
    assign wr_val = pwdata[CW-1:0];

    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        nc_next   = nc_reg;
        nr_next   = nr_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_COLS:
                begin
                    cols_next = wr_val;
                    nc_next   = (wr_val == '0) ? 11'd1 :
                                (wr_val > COL_CAP_V) ? COL_CAP_V : wr_val;
                end
                REG_ROWS:
                begin
                    rows_next = wr_val;
                    nr_next   = (wr_val == '0) ? 11'd1 :
                                (wr_val > ROW_CAP_V) ? ROW_CAP_V : wr_val;
                end
                default:
                begin
                    cols_next = cols_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= SIZE_RST;
            rows_reg <= SIZE_RST;
            nc_reg   <= COL_EFF_RST;
            nr_reg   <= ROW_EFF_RST;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
            nc_reg   <= nc_next;
            nr_reg   <= nr_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_COLS: prdata = {21'b0, cols_reg};
            REG_ROWS: prdata = {21'b0, rows_reg};
            default:  prdata = '0;
        endcase
    end

    hgni_coord u_coord (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .column    (column),
        .row       (row),
        .side      (side),
        .nc        (nc_reg),
        .nr        (nr_reg),
        .valid_reg (s1_valid),
        .coord_reg (s1_coord)
    );

    hgni_index u_index (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s1_valid),
        .coord         (s1_coord),
        .done          (done),
        .neighbor_cell (neighbor_cell),
        .edge_index    (edge_index),
        .vertex_index  (vertex_index),
        .invalid       (invalid)
    );

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##4 done)
        else $error("request did not produce a result after 4 cycles");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && invalid) |-> (neighbor_cell == '0 && edge_index == '0 &&
                               vertex_index == '0))
        else $error("rejected request gave nonzero indices");

    a_bad_side: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && side > SIDE_UW) |-> ##4 (done && invalid))
        else $error("side above five not flagged");

    a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (nc_reg != '0) && (nr_reg != '0))
        else $error("effective grid size is zero");

endmodule

FILE: verif/hex_grid_neighbor_index_top_tb.sv
`timescale 1ns / 100ps

module hex_grid_neighbor_index_top_tb
    import hgni_pkg::*;
;

    localparam int unsigned MAX_COLS      = 1024;
    localparam int unsigned MAX_ROWS_CFG  = 1024;
    localparam int          PIPE_LATENCY  = 4;
    localparam int          STALL_LIMIT   = 1000;
    localparam int          RANDOM_PHASES = 8;
    localparam int          PHASE_ITEMS   = 100;
    localparam logic [2:0]  SIDE_BAD_LO   = 3'd6;
    localparam logic [2:0]  SIDE_BAD_HI   = 3'd7;

    typedef struct {
        logic [19:0] neighbor_cell;
        logic [21:0] edge_index;
        logic [20:0] vertex_index;
        logic        invalid;
    } hex_indices_t;

    logic        clk;
    logic        rst_n   = 1'b0;
    logic        start   = 1'b0;
    logic        busy;
    logic [9:0]  column  = '0;
    logic [9:0]  row     = '0;
    logic [2:0]  side    = '0;
    logic        done;
    logic [19:0] neighbor_cell;
    logic [21:0] edge_index;
    logic [20:0] vertex_index;
    logic        invalid;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic [10:0]  grid_cols_reg = 11'd1024;
    logic [10:0]  grid_rows_reg = 11'd1024;
    hex_indices_t pending_indices[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    bit           no_gaps = 1'b0;

    hex_grid_neighbor_index_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .column        (column),
        .row           (row),
        .side          (side),
        .done          (done),
        .neighbor_cell (neighbor_cell),
        .edge_index    (edge_index),
        .vertex_index  (vertex_index),
        .invalid       (invalid),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic int unsigned eff_size(logic [10:0] value, int unsigned maxv);
        if (value == 0)
            return 1;
        if (value > maxv)
            return maxv;
        return value;
    endfunction

    function automatic int unsigned cell_toward(int unsigned col, int unsigned rw,
                                                int unsigned nc, int unsigned nr,
                                                side_t s);
        int unsigned west;
        int unsigned east;
        int unsigned down;
        int unsigned up;
        int unsigned c;
        int unsigned r;
        bit          even_row;
        west = (col == 0) ? nc - 1 : col - 1;
        east = (col == nc - 1) ? 0 : col + 1;
        down = (rw == 0) ? nr - 1 : rw - 1;
        up   = (rw == nr - 1) ? 0 : rw + 1;
        even_row = (rw % 2 == 0);
        c = col;
        r = rw;
        case (s)
            SIDE_W:  begin c = west;                   r = rw;   end
            SIDE_DW: begin c = even_row ? west : col;  r = down; end
            SIDE_DE: begin c = even_row ? col : east;  r = down; end
            SIDE_E:  begin c = east;                   r = rw;   end
            SIDE_UE: begin c = even_row ? col : east;  r = up;   end
            default: begin c = even_row ? west : col;  r = up;   end
        endcase
        return r * nc + c;
    endfunction

    function automatic hex_indices_t predict_indices(logic [9:0] col, logic [9:0] rw,
                                                     logic [2:0] sd);
        hex_indices_t res;
        int unsigned  nc;
        int unsigned  nr;
        int unsigned  own;
        int unsigned  nbr;
        int unsigned  edg;
        int unsigned  vtx;
        side_t        s;
        nc = eff_size(grid_cols_reg, MAX_COLS);
        nr = eff_size(grid_rows_reg, MAX_ROWS_CFG);
        res.neighbor_cell = '0;
        res.edge_index    = '0;
        res.vertex_index  = '0;
        res.invalid       = 1'b1;
        if (sd > SIDE_UW || col >= nc || rw >= nr)
            return res;
        s   = side_t'(sd);
        own = rw * nc + col;
        nbr = cell_toward(col, rw, nc, nr, s);
        if (s <= SIDE_DE)
            edg = 3 * own + sd;
        else
            edg = 3 * nbr + (sd - SIDE_E);
        case (s)
            SIDE_W:  vtx = 2 * own;
            SIDE_DW: vtx = 2 * own + 1;
            SIDE_DE: vtx = 2 * nbr;
            SIDE_E:  vtx = 2 * nbr + 1;
            SIDE_UE: vtx = 2 * cell_toward(col, rw, nc, nr, SIDE_E);
            default: vtx = 2 * cell_toward(col, rw, nc, nr, SIDE_UE) + 1;
        endcase
        res.neighbor_cell = nbr[19:0];
        res.edge_index    = edg[21:0];
        res.vertex_index  = vtx[20:0];
        res.invalid       = 1'b0;
        return res;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_indices.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                hex_indices_t exp_res;
                exp_res = pending_indices.pop_front();
                if (neighbor_cell !== exp_res.neighbor_cell)
                begin
                    $error("neighbor_cell: expected %0d, got %0d",
                           exp_res.neighbor_cell, neighbor_cell);
                    error_count++;
                end
                if (edge_index !== exp_res.edge_index)
                begin
                    $error("edge_index: expected %0d, got %0d",
                           exp_res.edge_index, edge_index);
                    error_count++;
                end
                if (vertex_index !== exp_res.vertex_index)
                begin
                    $error("vertex_index: expected %0d, got %0d",
                           exp_res.vertex_index, vertex_index);
                    error_count++;
                end
                if (invalid !== exp_res.invalid)
                begin
                    $error("invalid: expected %0d, got %0d", exp_res.invalid, invalid);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_request(logic [9:0] col, logic [9:0] rw, logic [2:0] sd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start  <= 1'b1;
        column <= col;
        row    <= rw;
        side   <= sd;
        do
            @(posedge clk);
        while (busy);
        pending_indices.push_back(predict_indices(col, rw, sd));
    endtask

    // drop start and let every outstanding request come back
    task automatic drain_requests();
        start <= 1'b0;
        do
            @(posedge clk);
        while (pending_indices.size() != 0);
    endtask

    task automatic write_grid_reg(reg_idx_t idx, logic [10:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {21'($urandom_range(0, 2097151)), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_COLS)
            grid_cols_reg = value;
        else
            grid_rows_reg = value;
        @(posedge clk);
    endtask

    task automatic set_grid(logic [10:0] cols, logic [10:0] rows);
        drain_requests();
        write_grid_reg(REG_COLS, cols);
        write_grid_reg(REG_ROWS, rows);
    endtask

    task automatic test_reset_grid();
        for (int s = SIDE_W; s <= SIDE_UW; s++)
        begin
            send_request(10'd0, 10'd0, s[2:0]);
            send_request(10'd1023, 10'd1023, s[2:0]);
        end
        send_request(10'd1023, 10'd0, SIDE_UE);
        send_request(10'd0, 10'd1, SIDE_W);
        send_request(10'd1023, 10'd1, SIDE_UE);
        send_request(10'd1023, 10'd1, SIDE_DE);
        send_request(10'd0, 10'd1023, SIDE_UW);
        send_request(10'd5, 10'd5, SIDE_BAD_LO);
        send_request(10'd1023, 10'd1023, SIDE_BAD_HI);
        send_request(10'd682, 10'd341, SIDE_DW);
    endtask

    task automatic test_size_limits();
        set_grid(11'd0, 11'd0);
        for (int s = SIDE_W; s <= SIDE_UW; s++)
            send_request(10'd0, 10'd0, s[2:0]);
        send_request(10'd1, 10'd0, SIDE_W);
        send_request(10'd0, 10'd1, SIDE_E);
        send_request(10'd1023, 10'd1023, SIDE_E);

        set_grid(11'd2047, 11'd2047);
        send_request(10'd1023, 10'd1023, SIDE_UE);
        send_request(10'd0, 10'd0, SIDE_DW);

        set_grid(11'd1, 11'd3);
        send_request(10'd0, 10'd2, SIDE_UE);
        send_request(10'd0, 10'd0, SIDE_DW);
        send_request(10'd0, 10'd1, SIDE_UW);
        send_request(10'd0, 10'd3, SIDE_W);

        set_grid(11'd2, 11'd1);
        send_request(10'd1, 10'd0, SIDE_E);
        send_request(10'd0, 10'd0, SIDE_UW);
        send_request(10'd2, 10'd0, SIDE_W);

        set_grid(11'd1024, 11'd1025);
        send_request(10'd1023, 10'd1023, SIDE_UE);

        set_grid(11'd1023, 11'd1023);
        send_request(10'd1023, 10'd0, SIDE_W);
        send_request(10'd1022, 10'd1022, SIDE_UE);
        send_request(10'd0, 10'd1023, SIDE_DW);
    endtask

    function automatic logic [10:0] pick_grid_size();
        case ($urandom_range(0, 5))
            0:       return 11'd0;
            1:       return 11'($urandom_range(1024, 2047));
            2:       return 11'($urandom_range(1, 8));
            3:       return 11'd1024;
            default: return 11'($urandom_range(1, 1024));
        endcase
    endfunction

    function automatic logic [9:0] pick_coord(int unsigned size);
        int unsigned lim;
        lim = (size > 1024) ? 1024 : size;
        case ($urandom_range(0, 9))
            0:       return 10'd0;
            1:       return 10'(lim - 1);
            default: return 10'($urandom_range(0, lim - 1));
        endcase
    endfunction

    task automatic test_random_traffic();
        int unsigned nc;
        int unsigned nr;
        int          kind;
        logic [9:0]  col;
        logic [9:0]  rw;
        logic [2:0]  sd;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph == 0)
                set_grid(11'd1024, 11'd1024);
            else
                set_grid(pick_grid_size(), pick_grid_size());
            nc = eff_size(grid_cols_reg, MAX_COLS);
            nr = eff_size(grid_rows_reg, MAX_ROWS_CFG);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i % 32 == 0)
                    no_gaps = ($urandom_range(0, 2) == 0);
                if (ph == RANDOM_PHASES / 2 && i == PHASE_ITEMS / 2)
                    drain_requests();
                kind = $urandom_range(0, 99);
                if (kind < 85)
                begin
                    col = pick_coord(nc);
                    rw  = pick_coord(nr);
                    sd  = 3'($urandom_range(SIDE_W, SIDE_UW));
                end
                else if (kind < 92)
                begin
                    col = 10'($urandom_range(0, 1023));
                    rw  = 10'($urandom_range(0, 1023));
                    sd  = 3'($urandom_range(SIDE_BAD_LO, SIDE_BAD_HI));
                end
                else
                begin
                    col = 10'($urandom_range(0, 1023));
                    rw  = 10'($urandom_range(0, 1023));
                    sd  = 3'($urandom_range(0, 7));
                end
                send_request(col, rw, sd);
            end
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_grid();
        test_size_limits();
        test_random_traffic();
        drain_requests();
        repeat (2 * PIPE_LATENCY) @(posedge clk);
        if (pending_indices.size() != 0)
        begin
            $error("%0d results never arrived", pending_indices.size());
            error_count++;
        end
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
